@@ rtl/ecfm_pkg.sv @@
// Shared types and constants for the encoder frame check and multi-turn unwrap.
// Holds the frame, queue entry and result layouts and the CRC-8 byte function.
// No dependencies.
package ecfm_pkg;

  localparam int ANGLE_BITS  = 21;
  localparam int ALARM_BITS  = 3;
  localparam int TURN_BITS   = 43;
  localparam int TOTAL_BITS  = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 224;

  localparam logic [7:0] CRC_POLY = 8'h07;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_ZERO_OFFSET = 2'd0;
  localparam logic [1:0] REG_DIR_INVERT  = 2'd1;
  localparam logic [1:0] REG_CRC_ENABLE  = 2'd2;

  // Frame disposition.
  typedef enum logic [1:0] {
    RC_ACCEPTED = 2'd0,
    RC_CRC_DROP = 2'd1,
    RC_BUS_DROP = 2'd2
  } result_code_t;

  // Input frame as it sits in tdata, highest byte first.
  typedef struct packed {
    logic [7:0] crc_byte;
    logic [7:0] angle_low_status_byte;
    logic [7:0] angle_mid_byte;
    logic [7:0] angle_high_byte;
  } in_data_t;

  // Classified frame passed from the front end to the back end.
  typedef struct packed {
    result_code_t          code;
    logic [ANGLE_BITS-1:0] angle;
    logic [ALARM_BITS-1:0] alarms;
  } entry_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle_zero;
    logic                  direction_invert;
    logic                  clear_baseline;
  } back_cfg_t;

  // Result layout in tdata, raw_angle in the lowest bits.
  typedef struct packed {
    logic [5:0]                   pad;
    logic [31:0]                  crc_error_count;
    logic [31:0]                  bus_error_count;
    logic                         healthy;
    logic                         frame_fault;
    logic signed [TURN_BITS-1:0]  turn_count;
    logic signed [TOTAL_BITS-1:0] count_total;
    logic [ANGLE_BITS-1:0]        adjusted_angle;
    logic [ALARM_BITS-1:0]        alarm_bits;
    logic [ANGLE_BITS-1:0]        raw_angle;
  } out_data_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/ecfm_front.sv @@
// Front end: accepts frames, checks bus error and CRC-8, and registers the
// classified entry for the queue. Depends on ecfm_pkg.
module ecfm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               crc_check_enable,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ecfm_pkg::in_data_t in_tdata,
  input  logic               in_tuser,
  output logic               push,
  output ecfm_pkg::entry_t   push_entry,
  input  logic               q_ready
);
  import ecfm_pkg::*;

  logic       fv_r, fv_nxt;
  entry_t     entry_r;
  entry_t     entry_nxt;
  logic [7:0] crc_calc;

  // CRC over the three data bytes, one byte step after another.
  assign crc_calc = crc8_byte(crc8_byte(crc8_byte(8'h00, in_tdata.angle_high_byte),
                                        in_tdata.angle_mid_byte),
                              in_tdata.angle_low_status_byte);

  // Classification: a bus error wins over the CRC check.
  always_comb begin
    entry_nxt.angle  = {in_tdata.angle_high_byte, in_tdata.angle_mid_byte,
                        in_tdata.angle_low_status_byte[7:3]};
    entry_nxt.alarms = in_tdata.angle_low_status_byte[2:0];
    priority if (in_tuser) begin
      entry_nxt.code = RC_BUS_DROP;
    end else if (crc_check_enable && (crc_calc != in_tdata.crc_byte)) begin
      entry_nxt.code = RC_CRC_DROP;
    end else begin
      entry_nxt.code = RC_ACCEPTED;
    end
  end

  assign in_tready  = !fv_r || q_ready;
  assign push       = fv_r && q_ready;
  assign push_entry = entry_r;

  always_comb begin
    fv_nxt = fv_r;
    if (in_tvalid && in_tready) begin
      fv_nxt = 1'b1;
    end else if (push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  // Payload register, loaded on every transfer.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

@@ rtl/ecfm_queue.sv @@
// Short queue of classified frames between the front and back ends.
// Depends on ecfm_pkg.
module ecfm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ecfm_pkg::entry_t push_entry,
  output logic             q_ready,
  input  logic             pop,
  output logic             q_valid,
  output ecfm_pkg::entry_t q_entry
);
  import ecfm_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  entry_t              mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wptr_r, wptr_nxt;
  logic [PTR_BITS-1:0] rptr_r, rptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  assign q_ready = (cnt_r != CNT_BITS'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_entry = mem_r[rptr_r];

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PTR_BITS'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PTR_BITS'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage, written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/ecfm_back.sv @@
// Back end: applies classified frames to the held state, unwraps turns into
// a saturating total and builds the registered result. Depends on ecfm_pkg.
module ecfm_back #(
  parameter int ERROR_COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ecfm_pkg::back_cfg_t cfg,
  input  logic                q_valid,
  input  ecfm_pkg::entry_t    q_entry,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output ecfm_pkg::out_data_t out_tdata,
  output logic [1:0]          out_tuser
);
  import ecfm_pkg::*;

  localparam logic signed [22:0] HALF_TURN  = 23'sd1048576;
  localparam logic signed [22:0] FULL_TURN  = 23'sd2097152;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
  localparam logic [TOTAL_BITS-1:0] TOTAL_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

  // Held state.
  logic                        base_r, base_nxt;
  logic [ANGLE_BITS-1:0]       prev_r, prev_nxt;
  logic signed [TOTAL_BITS-1:0] acc_r, acc_nxt;
  logic [ANGLE_BITS-1:0]       held_angle_r, held_angle_nxt;
  logic [ALARM_BITS-1:0]       held_alarms_r, held_alarms_nxt;
  logic                        fault_r, fault_nxt;
  logic [ERROR_COUNT_BITS-1:0] bus_cnt_r, bus_cnt_nxt;
  logic [ERROR_COUNT_BITS-1:0] crc_cnt_r, crc_cnt_nxt;

  // Pending result and output register.
  logic         pend_r, pend_nxt;
  result_code_t pend_code_r;
  logic         ov_r, ov_nxt;
  logic         pend_move;
  out_data_t    od_r, od_nxt;
  result_code_t oc_r;

  // Unwrap arithmetic.
  logic signed [22:0]           diff;
  logic signed [22:0]           wrapped;
  logic signed [22:0]           delta;
  logic [TOTAL_BITS-1:0]        sum;
  logic                         sum_ovf;

  // Result arithmetic.
  logic [ANGLE_BITS-1:0]        adj_base;
  logic [TOTAL_BITS-1:0]        turn_biased;

  assign pend_move = !ov_r || out_tready;
  assign pop       = q_valid && (!pend_r || pend_move);

  // Angle change across the half-turn boundary, direction applied.
  always_comb begin
    diff = $signed({2'b00, q_entry.angle}) - $signed({2'b00, prev_r});
    if (diff > HALF_TURN) begin
      wrapped = diff - FULL_TURN;
    end else if (diff < -HALF_TURN) begin
      wrapped = diff + FULL_TURN;
    end else begin
      wrapped = diff;
    end
    delta   = cfg.direction_invert ? -wrapped : wrapped;
    sum     = acc_r + {{(TOTAL_BITS-23){delta[22]}}, delta};
    sum_ovf = (acc_r[TOTAL_BITS-1] == delta[22]) && (sum[TOTAL_BITS-1] != acc_r[TOTAL_BITS-1]);
  end

  // State update for the frame taken from the queue; a baseline clear wins over it.
  always_comb begin
    base_nxt        = base_r;
    prev_nxt        = prev_r;
    acc_nxt         = acc_r;
    held_angle_nxt  = held_angle_r;
    held_alarms_nxt = held_alarms_r;
    fault_nxt       = fault_r;
    bus_cnt_nxt     = bus_cnt_r;
    crc_cnt_nxt     = crc_cnt_r;
    if (cfg.clear_baseline) begin
      base_nxt = 1'b0;
      acc_nxt  = '0;
    end else if (pop) begin
      unique case (q_entry.code)
        RC_BUS_DROP: begin
          bus_cnt_nxt = bus_cnt_r + ERROR_COUNT_BITS'(1);
        end
        RC_CRC_DROP: begin
          crc_cnt_nxt = crc_cnt_r + ERROR_COUNT_BITS'(1);
          fault_nxt   = 1'b1;
        end
        RC_ACCEPTED: begin
          fault_nxt       = 1'b0;
          held_angle_nxt  = q_entry.angle;
          held_alarms_nxt = q_entry.alarms;
          prev_nxt        = q_entry.angle;
          base_nxt        = 1'b1;
          if (!base_r) begin
            acc_nxt = '0;
          end else if (sum_ovf) begin
            acc_nxt = delta[22] ? TOTAL_MIN : TOTAL_MAX;
          end else begin
            acc_nxt = sum;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r        <= 1'b0;
      prev_r        <= '0;
      acc_r         <= '0;
      held_angle_r  <= '0;
      held_alarms_r <= '0;
      fault_r       <= 1'b0;
      bus_cnt_r     <= '0;
      crc_cnt_r     <= '0;
    end else begin
      base_r        <= base_nxt;
      prev_r        <= prev_nxt;
      acc_r         <= acc_nxt;
      held_angle_r  <= held_angle_nxt;
      held_alarms_r <= held_alarms_nxt;
      fault_r       <= fault_nxt;
      bus_cnt_r     <= bus_cnt_nxt;
      crc_cnt_r     <= crc_cnt_nxt;
    end
  end

  // Result fields from the state left by the pending frame.
  always_comb begin
    adj_base    = held_angle_r - cfg.angle_zero;
    turn_biased = acc_r + (acc_r[TOTAL_BITS-1] ? TOTAL_BITS'((64'd1 << ANGLE_BITS) - 64'd1)
                                               : '0);
    od_nxt.pad             = '0;
    od_nxt.raw_angle       = held_angle_r;
    od_nxt.alarm_bits      = held_alarms_r;
    od_nxt.adjusted_angle  = cfg.direction_invert ? -adj_base : adj_base;
    od_nxt.count_total     = acc_r;
    od_nxt.turn_count      = turn_biased[TOTAL_BITS-1:ANGLE_BITS];
    od_nxt.frame_fault     = fault_r;
    od_nxt.healthy         = base_r && !fault_r && (held_alarms_r == '0);
    od_nxt.bus_error_count = 32'(bus_cnt_r);
    od_nxt.crc_error_count = 32'(crc_cnt_r);
  end

  // Pending flag and output valid.
  always_comb begin
    pend_nxt = pend_r;
    ov_nxt   = ov_r;
    if (pend_r && pend_move) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
    if (pop) begin
      pend_nxt = 1'b1;
    end else if (pend_move) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      pend_code_r <= q_entry.code;
    end
    if (pend_r && pend_move) begin
      od_r <= od_nxt;
      oc_r <= pend_code_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = oc_r;

endmodule

@@ rtl/encoder_frame_check_multiturn.sv @@
// Top level of the encoder frame check and multi-turn unwrap.
// Instantiates ecfm_front, ecfm_queue and ecfm_back; uses ecfm_pkg.
//
// The block takes one received 32-bit encoder frame (21-bit angle) per
// transfer and returns one result per frame, in order. Frames are accepted
// at one per clock cycle while the output side does not stall; a result
// passes the front classify register, a queue slot, the state update and
// the output register. The unwrap and saturating 64-bit add are done
// combinationally in the back end state update. A two entry queue lets the
// front keep accepting while the output side stalls, until it fills.
// Writing the zero offset or the direction register clears the turn
// baseline; the next good frame starts a new total at zero.
module encoder_frame_check_multiturn #(
  parameter int ERROR_COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [20:0]  cfg_wdata,
  // Frame input.
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0: angle_high_byte, angle_mid_byte, angle_low_status_byte, crc_byte.
  input  logic [31:0]  in_tdata,
  // Fields from bit 0: bus_error.
  input  logic         in_tuser,
  // Result output.
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0: raw_angle, alarm_bits, adjusted_angle, total count,
  // turn_count, CRC fault, healthy, bus_error_count, crc_error_count, zero pad.
  output logic [223:0] out_tdata,
  // Fields from bit 0: result_code.
  output logic [1:0]   out_tuser
);
  import ecfm_pkg::*;

  logic [ANGLE_BITS-1:0] angle_zero_r;
  logic                  dir_inv_r;
  logic                  crc_en_r;
  back_cfg_t             bcfg;
  logic                  push;
  entry_t                push_entry;
  logic                  q_ready;
  logic                  q_valid;
  entry_t                q_entry;
  logic                  pop;
  out_data_t             od;
  in_data_t              id;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_zero_r <= '0;
      dir_inv_r    <= 1'b0;
      crc_en_r     <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == REG_ZERO_OFFSET) begin
        angle_zero_r <= cfg_wdata[ANGLE_BITS-1:0];
      end
      if (cfg_index == REG_DIR_INVERT) begin
        dir_inv_r <= cfg_wdata[0];
      end
      if (cfg_index == REG_CRC_ENABLE) begin
        crc_en_r <= cfg_wdata[0];
      end
    end
  end

  assign bcfg.angle_zero       = angle_zero_r;
  assign bcfg.direction_invert = dir_inv_r;
  assign bcfg.clear_baseline   = cfg_we && ((cfg_index == REG_ZERO_OFFSET) ||
                                            (cfg_index == REG_DIR_INVERT));

  assign id = in_tdata;

  ecfm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .crc_check_enable (crc_en_r),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (id),
    .in_tuser         (in_tuser),
    .push             (push),
    .push_entry       (push_entry),
    .q_ready          (q_ready)
  );

  ecfm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  ecfm_back #(
    .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (bcfg),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (od),
    .out_tuser  (out_tuser)
  );

  assign out_tdata = od;

  // A healthy result never shows a CRC fault or a raised alarm.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(od.healthy && (od.frame_fault || (od.alarm_bits != '0))))
    else $error("healthy set with fault or alarm");

  // The fault flag follows the disposition of checked frames.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == RC_CRC_DROP)) |-> od.frame_fault)
    else $error("CRC drop without fault flag");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == RC_ACCEPTED)) |-> !od.frame_fault)
    else $error("accepted frame with fault flag");

  // A nonzero turn count carries the sign of the total.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (od.turn_count != '0)) |->
      (od.turn_count[TURN_BITS-1] == od.count_total[TOTAL_BITS-1]))
    else $error("turn count sign differs from total");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench for encoder_frame_check_multiturn: frame CRC check, drop handling and
// multi-turn unwrap are checked against a scoreboard that tracks the block's state.
// Depends on ecfm_pkg and the encoder_frame_check_multiturn RTL.
module tb;
  import ecfm_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int HALF_TURN = 1048576;
  localparam longint COUNTS_PER_TURN = 64'sd2097152;
  localparam longint TOTAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint TOTAL_MIN = -TOTAL_MAX - 1;
  localparam int RANDOM_FRAMES = 1500;

  // One expected result, field by field.
  typedef struct {
    result_code_t code;
    bit [20:0]    raw_angle;
    bit [2:0]     alarm_bits;
    bit [20:0]    adjusted_angle;
    longint       count_total;
    bit [42:0]    turn_count;
    bit           frame_fault;
    bit           healthy;
    bit [31:0]    bus_error_count;
    bit [31:0]    crc_error_count;
  } frame_result_t;

  // Tracks the encoder state and the results still owed by the block.
  class encoder_scoreboard;
    bit [20:0] angle_zero;
    bit        dir_flip;
    bit        crc_enable;
    bit        baseline_ok;
    bit [20:0] last_angle;
    longint    total;
    bit [20:0] held_angle;
    bit [2:0]  held_alarms;
    bit        fault;
    bit [31:0] bus_errs;
    bit [31:0] crc_errs;
    frame_result_t pending_results[$];
    int failures;

    function new();
      crc_enable = 1'b1;
    endfunction

    // CRC-8 over the three data bytes, polynomial 0x07, MSB first, start value 0.
    static function bit [7:0] frame_crc(bit [7:0] b0, bit [7:0] b1, bit [7:0] b2);
      bit [7:0] c;
      bit [7:0] data [3];
      c = 8'h00;
      data = '{b0, b1, b2};
      foreach (data[k]) begin
        c = c ^ data[k];
        for (int i = 0; i < 8; i++) begin
          c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
      end
      return c;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // A write to the offset or the direction drops the turn baseline.
    function void apply_register(logic [1:0] idx, logic [20:0] value);
      case (idx)
        REG_ZERO_OFFSET: begin
          angle_zero = value;
          baseline_ok = 1'b0;
          total = 0;
        end
        REG_DIR_INVERT: begin
          dir_flip = value[0];
          baseline_ok = 1'b0;
          total = 0;
        end
        REG_CRC_ENABLE: crc_enable = value[0];
        default: ;
      endcase
    endfunction

    // Advances the state by one accepted frame and queues the result it owes.
    function void track_frame(in_data_t f, bit berr);
      frame_result_t r;
      bit [20:0] angle;
      bit [20:0] adj;
      longint step;
      r.code = RC_ACCEPTED;
      if (berr) begin
        bus_errs++;
        r.code = RC_BUS_DROP;
      end else if (crc_enable && frame_crc(f.angle_high_byte, f.angle_mid_byte,
                                           f.angle_low_status_byte) != f.crc_byte) begin
        crc_errs++;
        fault = 1'b1;
        r.code = RC_CRC_DROP;
      end else begin
        angle = {f.angle_high_byte, f.angle_mid_byte, f.angle_low_status_byte[7:3]};
        fault = 1'b0;
        held_angle = angle;
        held_alarms = f.angle_low_status_byte[2:0];
        if (!baseline_ok) begin
          // First good sample after reset or a baseline clear starts from zero.
          baseline_ok = 1'b1;
          total = 0;
        end else begin
          // Shortest way round the circle, then direction, then saturating add.
          step = longint'(angle) - longint'(last_angle);
          if (step > HALF_TURN) step -= COUNTS_PER_TURN;
          else if (step < -HALF_TURN) step += COUNTS_PER_TURN;
          if (dir_flip) step = -step;
          if (step > 0 && total > TOTAL_MAX - step) total = TOTAL_MAX;
          else if (step < 0 && total < TOTAL_MIN - step) total = TOTAL_MIN;
          else total += step;
        end
        last_angle = angle;
      end
      adj = held_angle - angle_zero;
      if (dir_flip) adj = 21'd0 - adj;
      r.raw_angle       = held_angle;
      r.alarm_bits      = held_alarms;
      r.adjusted_angle  = adj;
      r.count_total     = total;
      r.turn_count      = 43'(total / COUNTS_PER_TURN);
      r.frame_fault     = fault;
      r.healthy         = baseline_ok && !fault && (held_alarms == 3'd0);
      r.bus_error_count = bus_errs;
      r.crc_error_count = crc_errs;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= 10)
          $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
      end
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void check_result(out_data_t d, logic [1:0] code);
      frame_result_t r;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10) $display("%0t: result with no frame behind it", $realtime);
        return;
      end
      r = pending_results.pop_front();
      compare_field("result_code", 64'(r.code), 64'(code));
      compare_field("raw_angle", 64'(r.raw_angle), 64'(d.raw_angle));
      compare_field("alarm_bits", 64'(r.alarm_bits), 64'(d.alarm_bits));
      compare_field("adjusted_angle", 64'(r.adjusted_angle), 64'(d.adjusted_angle));
      compare_field("count_total", r.count_total, d.count_total);
      compare_field("turn_count", 64'(r.turn_count), 64'(unsigned'(d.turn_count)));
      compare_field("frame_fault", 64'(r.frame_fault), 64'(d.frame_fault));
      compare_field("healthy", 64'(r.healthy), 64'(d.healthy));
      compare_field("bus_error_count", 64'(r.bus_error_count), 64'(d.bus_error_count));
      compare_field("crc_error_count", 64'(r.crc_error_count), 64'(d.crc_error_count));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [20:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [223:0] out_tdata;
  logic [1:0]   out_tuser;

  encoder_scoreboard sb = new();
  bit        no_idle;
  bit [20:0] cur_angle;
  int        random_sent;

  encoder_frame_check_multiturn dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic in_data_t make_frame(bit [20:0] a, bit [2:0] al, bit good);
    in_data_t f;
    f.angle_high_byte = a[20:13];
    f.angle_mid_byte = a[12:5];
    f.angle_low_status_byte = {a[4:0], al};
    f.crc_byte = encoder_scoreboard::frame_crc(f.angle_high_byte, f.angle_mid_byte,
                                               f.angle_low_status_byte);
    if (!good) f.crc_byte ^= 8'($urandom_range(1, 255));
    return f;
  endfunction

  // Offers one frame after a random gap and notes it once the transfer happens.
  task automatic send_frame(in_data_t f, bit berr);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= f;
    in_tuser <= berr;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.track_frame(f, berr);
  endtask

  // Stops offering frames and waits for every owed result.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [20:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.apply_register(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Frames walking the angle, half of them in noisy mode and most otherwise; the rest are drops and noise.
  task automatic send_random_frame(bit spin, bit noisy, int bias);
    int roll;
    int delta;
    bit [2:0] al;
    in_data_t f;
    roll = $urandom_range(0, 99);
    al = ($urandom_range(0, 9) < 7) ? 3'd0 : 3'($urandom_range(0, 7));
    if (roll < (noisy ? 20 : 5)) begin
      f = $urandom;
      send_frame(f, 1'b1);
    end else if (roll < (noisy ? 40 : 10)) begin
      send_frame(make_frame(21'($urandom), al, 1'b0), 1'b0);
    end else if (roll < (noisy ? 50 : 13)) begin
      f = $urandom;
      send_frame(f, 1'b0);
    end else begin
      roll = $urandom_range(0, 9);
      if (spin && roll < 7) roll = 6;
      case (roll)
        0, 1, 2, 3: delta = $urandom_range(0, 255);
        4, 5:       delta = $urandom_range(0, 65535);
        6, 7:       delta = HALF_TURN - 3 + $urandom_range(0, 6);
        8:          delta = $urandom_range(0, 2097151);
        default:    delta = 0;
      endcase
      if (roll == 6 || roll == 7) delta = delta * bias;
      else if ($urandom_range(0, 1)) delta = -delta;
      cur_angle = cur_angle + 21'(delta);
      send_frame(make_frame(cur_angle, al, 1'b1), 1'b0);
    end
    random_sent++;
  endtask

  // Result side: random stalls before each transfer, then the check.
  initial begin
    forever begin
      int stall;
      stall = draw_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_result(out_data_t'(out_tdata), out_tuser);
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Directed frames, then random phases with a new register setting each.
  initial begin
    int phase_len;
    int bias;
    bit spin;
    bit noisy;
    in_data_t f;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Baseline, extremes, exact half turns and the wrap one count past it.
    send_frame(make_frame(21'd0, 3'd0, 1'b1), 1'b0);
    send_frame(make_frame(21'h1FFFFF, 3'd7, 1'b1), 1'b0);
    send_frame(make_frame(21'd0, 3'd0, 1'b1), 1'b0);
    send_frame(make_frame(21'(HALF_TURN), 3'd0, 1'b1), 1'b0);
    send_frame(make_frame(21'd0, 3'd0, 1'b1), 1'b0);
    send_frame(make_frame(21'(HALF_TURN + 1), 3'd1, 1'b1), 1'b0);
    // CRC mismatch, then bus errors that win over the CRC and keep the fault.
    send_frame(make_frame(21'h0ABCDE, 3'd0, 1'b0), 1'b0);
    send_frame(make_frame(21'h012345, 3'd0, 1'b1), 1'b1);
    send_frame(make_frame(21'h054321, 3'd0, 1'b0), 1'b1);
    send_frame(make_frame(21'h1FFFFF, 3'd7, 1'b1), 1'b0);
    f = '0;
    f.crc_byte = 8'hFF;
    send_frame(f, 1'b0);
    send_frame(make_frame(21'h100000, 3'd2, 1'b1), 1'b0);
    send_frame(make_frame(21'h0FFFFF, 3'd4, 1'b1), 1'b0);
    // With checking off a bad CRC is accepted; the enable write keeps the baseline.
    settle();
    write_register(REG_CRC_ENABLE, 21'h1FFFFE);
    send_frame(make_frame(21'h0F0F0F, 3'd0, 1'b0), 1'b0);
    send_frame(make_frame(21'h0F0F0F, 3'd0, 1'b0), 1'b1);
    settle();
    write_register(REG_SPARE, 21'h1FFFFF);
    write_register(REG_CRC_ENABLE, 21'h000003);
    send_frame(make_frame(21'h0F1000, 3'd0, 1'b1), 1'b0);
    settle();
    write_register(REG_ZERO_OFFSET, 21'h1FFFFF);
    send_frame(make_frame(21'd5, 3'd0, 1'b1), 1'b0);
    send_frame(make_frame(21'(HALF_TURN + 10), 3'd0, 1'b1), 1'b0);
    settle();
    write_register(REG_DIR_INVERT, 21'h1FFFFF);
    send_frame(make_frame(21'd100, 3'd0, 1'b1), 1'b0);
    send_frame(make_frame(21'd50, 3'd0, 1'b1), 1'b0);
    send_frame(make_frame(21'h1FFF00, 3'd0, 1'b1), 1'b0);
    settle();
    write_register(REG_ZERO_OFFSET, 21'd0);
    send_frame(make_frame(21'd0, 3'd0, 1'b1), 1'b0);
    settle();

    while (random_sent < RANDOM_FRAMES) begin
      case ($urandom_range(0, 2))
        0: write_register(REG_ZERO_OFFSET, 21'd0);
        1: write_register(REG_ZERO_OFFSET, 21'h1FFFFF);
        default: if ($urandom_range(0, 1)) write_register(REG_ZERO_OFFSET, 21'($urandom));
      endcase
      if ($urandom_range(0, 2) != 0) write_register(REG_DIR_INVERT, 21'($urandom));
      if ($urandom_range(0, 2) != 0)
        write_register(REG_CRC_ENABLE, {20'($urandom), ($urandom_range(0, 3) != 0)});
      if ($urandom_range(0, 7) == 0) write_register(REG_SPARE, 21'($urandom));
      no_idle = ($urandom_range(0, 3) == 0);
      spin = ($urandom_range(0, 2) == 0);
      noisy = ($urandom_range(0, 3) == 0);
      bias = $urandom_range(0, 1) ? 1 : -1;
      phase_len = $urandom_range(60, 200);
      repeat (phase_len) send_random_frame(spin, noisy, bias);
      settle();
    end

    no_idle = 1'b0;
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ecfm_pkg.sv
rtl/ecfm_front.sv
rtl/ecfm_queue.sv
rtl/ecfm_back.sv
rtl/encoder_frame_check_multiturn.sv
bench/tb.sv
